>>> rtl/dds_pkg.sv
// Shared types, widths and constants of the steering and wheel speed controller.
package dds_pkg;

    localparam int PWM_LIMIT_DEF      = 1000;
    localparam int INTEGRAL_LIMIT_DEF = 1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LINE_W   = 16;
    localparam int GYRO_W   = 16;
    localparam int SPEED_W  = 13;
    localparam int DRIVE_W  = 11;
    localparam int STEER_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int WGAIN_W  = 10;
    localparam int BASE_W   = 12;

    localparam int E_W      = 17;
    localparam int DE_W     = 18;
    localparam int EE_W     = 32;
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = 50;
    localparam int SACC_W   = 50;
    localparam int FRAC_W   = 24;
    localparam int KD_SH    = 8;
    localparam int KDD_SH   = 16;
    localparam int KQ_W     = 25;
    localparam int FAC_W    = 26;
    localparam int TGT_W    = 21;
    localparam int DIF_W    = 22;
    localparam int WERR_W   = 18;
    localparam int WDERR_W  = 19;
    localparam int WACC_W   = 32;

    localparam int DEAD_ZONE     = 5;
    localparam int FRAC_ONE      = 2 ** FRAC_W;
    localparam int SPLIT_Q16     = 524;
    localparam int SPLIT_IN_SH   = 16;
    localparam int SPLIT_OUT_SH  = 17;
    localparam int SPLIT_ONE_IN  = 2 ** SPLIT_IN_SH;
    localparam int SPLIT_ONE_OUT = 2 ** SPLIT_OUT_SH;
    localparam int STEER_MAX     = 32767;
    localparam int STEER_MIN     = -32768;
    localparam int WERR_MAX      = 131071;
    localparam int WERR_MIN      = -131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_KP,
        CFG_STEER_KPP,
        CFG_STEER_KD,
        CFG_STEER_KDD,
        CFG_WHEEL_KP,
        CFG_WHEEL_KI,
        CFG_WHEEL_KD,
        CFG_BASE_SPEED
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]         steer_kp;
        logic [GAIN_W-1:0]         steer_kpp;
        logic [GAIN_W-1:0]         steer_kd;
        logic [GAIN_W-1:0]         steer_kdd;
        logic [WGAIN_W-1:0]        wheel_kp;
        logic [WGAIN_W-1:0]        wheel_ki;
        logic [WGAIN_W-1:0]        wheel_kd;
        logic signed [BASE_W-1:0]  base_speed;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        steer_kp:   16'd8960,
        steer_kpp:  16'd0,
        steer_kd:   16'd256,
        steer_kdd:  16'd26,
        wheel_kp:   10'd200,
        wheel_ki:   10'd1,
        wheel_kd:   10'd100,
        base_speed: 12'sd0
    };

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MS_NONE,
        MS_EE,
        MS_KP,
        MS_KPP,
        MS_KD,
        MS_KDD,
        MS_IN,
        MS_OUT,
        MS_LP,
        MS_LI,
        MS_LD,
        MS_RP,
        MS_RI,
        MS_RD
    } t_msel;

    typedef struct packed {
        logic  load;
        t_msel msel;
        logic  steer;
        logic  kq;
        logic  err;
        logic  integ;
        logic  fin;
    } t_dp_cmd;

endpackage

>>> rtl/dds_if.sv
// Channel interfaces: control tick input, drive result output, register writes.
interface dds_in_if;
    import dds_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [LINE_W-1:0]  line_error;
    logic signed [GYRO_W-1:0]  gyro_rate;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
    modport source (output valid, output line_error, output gyro_rate,
                    output speed_left, output speed_right, input ready);
    modport sink   (input valid, input line_error, input gyro_rate,
                    input speed_left, input speed_right, output ready);
endinterface

interface dds_out_if;
    import dds_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic signed [STEER_W-1:0] steer_out;
    modport source (output valid, output drive_left, output drive_right,
                    output steer_out, input ready);
    modport sink   (input valid, input drive_left, input drive_right,
                    input steer_out, output ready);
endinterface

interface dds_cfg_if;
    import dds_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

>>> rtl/dds_cfg_regs.sv
// Configuration register file, written one register per transfer.
module dds_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dds_cfg_if.sink       i_cfg,
    output dds_pkg::t_cfg o_cfg
);
    import dds_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                CFG_STEER_KP:   r_cfg.steer_kp   <= i_cfg.data;
                CFG_STEER_KPP:  r_cfg.steer_kpp  <= i_cfg.data;
                CFG_STEER_KD:   r_cfg.steer_kd   <= i_cfg.data;
                CFG_STEER_KDD:  r_cfg.steer_kdd  <= i_cfg.data;
                CFG_WHEEL_KP:   r_cfg.wheel_kp   <= i_cfg.data[WGAIN_W-1:0];
                CFG_WHEEL_KI:   r_cfg.wheel_ki   <= i_cfg.data[WGAIN_W-1:0];
                CFG_WHEEL_KD:   r_cfg.wheel_kd   <= i_cfg.data[WGAIN_W-1:0];
                CFG_BASE_SPEED: r_cfg.base_speed <= i_cfg.data[BASE_W-1:0];
            endcase
        end
    end

endmodule

>>> rtl/dds_ctrl.sv
// Sequencer: steps the shared multiplier and datapath through one control tick.
module dds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dds_pkg::t_dp_cmd o_cmd
);
    import dds_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EE,
        S_KP,
        S_KPP,
        S_KD,
        S_KDD,
        S_W1,
        S_STEER,
        S_KQ,
        S_IN,
        S_OUT,
        S_W2,
        S_ERR,
        S_INT,
        S_LD,
        S_LI,
        S_RP,
        S_RD,
        S_RI,
        S_W3,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_load;
    logic   w_fin;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_load      = i_in_valid && (r_state == S_IDLE);
    assign w_fin       = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_load ? S_EE : S_IDLE;
            S_EE:    n_state = S_KP;
            S_KP:    n_state = S_KPP;
            S_KPP:   n_state = S_KD;
            S_KD:    n_state = S_KDD;
            S_KDD:   n_state = S_W1;
            S_W1:    n_state = S_STEER;
            S_STEER: n_state = S_KQ;
            S_KQ:    n_state = S_IN;
            S_IN:    n_state = S_OUT;
            S_OUT:   n_state = S_W2;
            S_W2:    n_state = S_ERR;
            S_ERR:   n_state = S_INT;
            S_INT:   n_state = S_LD;
            S_LD:    n_state = S_LI;
            S_LI:    n_state = S_RP;
            S_RP:    n_state = S_RD;
            S_RD:    n_state = S_RI;
            S_RI:    n_state = S_W3;
            S_W3:    n_state = S_FIN;
            S_FIN:   n_state = w_fin ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.msel = MS_NONE;
        o_cmd.load = w_load;
        o_cmd.fin  = w_fin;
        unique case (r_state)
            S_EE:    o_cmd.msel = MS_EE;
            S_KP:    o_cmd.msel = MS_KP;
            S_KPP:   o_cmd.msel = MS_KPP;
            S_KD:    o_cmd.msel = MS_KD;
            S_KDD:   o_cmd.msel = MS_KDD;
            S_STEER: o_cmd.steer = 1'b1;
            S_KQ:    o_cmd.kq = 1'b1;
            S_IN:    o_cmd.msel = MS_IN;
            S_OUT:   o_cmd.msel = MS_OUT;
            S_ERR:   o_cmd.err = 1'b1;
            S_INT: begin
                o_cmd.integ = 1'b1;
                o_cmd.msel  = MS_LP;
            end
            S_LD:    o_cmd.msel = MS_LD;
            S_LI:    o_cmd.msel = MS_LI;
            S_RP:    o_cmd.msel = MS_RP;
            S_RD:    o_cmd.msel = MS_RD;
            S_RI:    o_cmd.msel = MS_RI;
            default: o_cmd.msel = MS_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final step");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready)
            |=> (r_state == S_FIN && r_out_valid))
        else $error("final step left while the output register was full");

endmodule

>>> rtl/dds_dp.sv
// Datapath: shared multiplier, steering sum, differential split and wheel PIDs.
module dds_dp #(
    parameter int PWM_LIMIT      = dds_pkg::PWM_LIMIT_DEF,
    parameter int INTEGRAL_LIMIT = dds_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dds_pkg::t_dp_cmd                  i_cmd,
    input  dds_pkg::t_cfg                     i_cfg,
    input  logic signed [dds_pkg::LINE_W-1:0]  i_line_error,
    input  logic signed [dds_pkg::GYRO_W-1:0]  i_gyro_rate,
    input  logic signed [dds_pkg::SPEED_W-1:0] i_speed_left,
    input  logic signed [dds_pkg::SPEED_W-1:0] i_speed_right,
    output logic signed [dds_pkg::DRIVE_W-1:0] o_drive_left,
    output logic signed [dds_pkg::DRIVE_W-1:0] o_drive_right,
    output logic signed [dds_pkg::STEER_W-1:0] o_steer_out
);
    import dds_pkg::*;

    localparam int IW     = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int ISUM_W = ((IW > WERR_W) ? IW : WERR_W) + 1;

    localparam logic signed [SACC_W-1:0] DZ_HI = SACC_W'(DEAD_ZONE * FRAC_ONE);
    localparam logic signed [SACC_W-1:0] DZ_LO = -DZ_HI;

    function automatic logic signed [WERR_W-1:0] f_sat_err(
        input logic signed [DIF_W-1:0] v
    );
        logic signed [WERR_W-1:0] r;
        if (v > DIF_W'(WERR_MAX)) begin
            r = WERR_W'(WERR_MAX);
        end else if (v < DIF_W'(WERR_MIN)) begin
            r = WERR_W'(WERR_MIN);
        end else begin
            r = WERR_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [IW-1:0] f_sat_int(
        input logic signed [ISUM_W-1:0] v
    );
        logic signed [IW-1:0] r;
        if (v > ISUM_W'(INTEGRAL_LIMIT)) begin
            r = IW'(INTEGRAL_LIMIT);
        end else if (v < ISUM_W'(-INTEGRAL_LIMIT)) begin
            r = IW'(-INTEGRAL_LIMIT);
        end else begin
            r = IW'(v);
        end
        return r;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] f_sat_pwm(
        input logic signed [WACC_W-1:0] v
    );
        logic signed [WACC_W-1:0] r;
        if (v > WACC_W'(PWM_LIMIT)) begin
            r = WACC_W'(PWM_LIMIT);
        end else if (v < WACC_W'(-PWM_LIMIT)) begin
            r = WACC_W'(-PWM_LIMIT);
        end else begin
            r = v;
        end
        return r[DRIVE_W-1:0];
    endfunction

    // steering terms
    logic signed [E_W-1:0]     r_e;
    logic        [E_W-1:0]     r_abse;
    logic signed [DE_W-1:0]    r_de;
    logic signed [E_W-1:0]     r_prev_e;
    logic signed [GYRO_W-1:0]  r_gyro;
    logic signed [SPEED_W-1:0] r_sl;
    logic signed [SPEED_W-1:0] r_sr;
    logic signed [EE_W-1:0]    r_ee;
    logic signed [SACC_W-1:0]  r_sacc;
    logic signed [STEER_W-1:0] r_steer;
    logic        [KQ_W-1:0]    r_kq;
    logic signed [TGT_W-1:0]   r_tin;
    logic signed [TGT_W-1:0]   r_tout;

    // shared multiplier
    logic signed [MUL_A_W-1:0] w_opa;
    logic signed [MUL_B_W-1:0] w_opb;
    logic signed [PROD_W-1:0]  r_prod;
    t_msel                     r_msel_q;

    // wheel loops
    logic signed [WERR_W-1:0]  r_errl;
    logic signed [WERR_W-1:0]  r_errr;
    logic signed [WDERR_W-1:0] r_del;
    logic signed [WDERR_W-1:0] r_der;
    logic signed [WERR_W-1:0]  r_lprev;
    logic signed [WERR_W-1:0]  r_rprev;
    logic signed [IW-1:0]      r_lint;
    logic signed [IW-1:0]      r_rint;
    logic signed [WACC_W-1:0]  r_lacc;
    logic signed [WACC_W-1:0]  r_racc;

    logic signed [DRIVE_W-1:0] r_drive_l;
    logic signed [DRIVE_W-1:0] r_drive_r;
    logic signed [STEER_W-1:0] r_steer_out;

    logic signed [E_W-1:0]     w_e;
    logic        [E_W-1:0]     w_abse;
    logic signed [FAC_W-1:0]   w_fac_in;
    logic signed [FAC_W-1:0]   w_fac_out;
    logic signed [PROD_W-1:0]  w_rnd_in;
    logic signed [PROD_W-1:0]  w_rnd_out;
    logic signed [TGT_W-1:0]   w_tin;
    logic signed [TGT_W-1:0]   w_tout;
    logic signed [SACC_W-1:0]  w_srnd;
    logic signed [SACC_W-1:0]  w_sq;
    logic signed [STEER_W-1:0] w_steer;
    logic                      w_dead;
    logic        [E_W-1:0]     w_mag;
    logic signed [TGT_W-1:0]   w_tl;
    logic signed [TGT_W-1:0]   w_tr;
    logic signed [WERR_W-1:0]  w_errl;
    logic signed [WERR_W-1:0]  w_errr;

    assign o_drive_left  = r_drive_l;
    assign o_drive_right = r_drive_r;
    assign o_steer_out   = r_steer_out;

    always_comb begin
        w_e    = E_W'(0) - E_W'(i_line_error);
        w_abse = i_line_error[LINE_W-1] ? (E_W'(0) - E_W'(i_line_error))
                                        : E_W'(i_line_error);
    end

    always_comb begin
        w_fac_in  = $signed(FAC_W'(SPLIT_ONE_IN)) - $signed(FAC_W'(r_kq));
        w_fac_out = $signed(FAC_W'(SPLIT_ONE_OUT)) + $signed(FAC_W'(r_kq));
    end

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (i_cmd.msel)
            MS_EE: begin
                w_opa = MUL_A_W'(r_e);
                w_opb = MUL_B_W'(r_abse);
            end
            MS_KP: begin
                w_opa = MUL_A_W'(i_cfg.steer_kp);
                w_opb = MUL_B_W'(r_e);
            end
            MS_KPP: begin
                w_opa = MUL_A_W'(i_cfg.steer_kpp);
                w_opb = r_ee;
            end
            MS_KD: begin
                w_opa = MUL_A_W'(i_cfg.steer_kd);
                w_opb = MUL_B_W'(r_de);
            end
            MS_KDD: begin
                w_opa = MUL_A_W'(i_cfg.steer_kdd);
                w_opb = MUL_B_W'(r_gyro);
            end
            MS_IN: begin
                w_opa = MUL_A_W'(i_cfg.base_speed);
                w_opb = MUL_B_W'(w_fac_in);
            end
            MS_OUT: begin
                w_opa = MUL_A_W'(i_cfg.base_speed);
                w_opb = MUL_B_W'(w_fac_out);
            end
            MS_LP: begin
                w_opa = MUL_A_W'(i_cfg.wheel_kp);
                w_opb = MUL_B_W'(r_errl);
            end
            MS_LI: begin
                w_opa = MUL_A_W'(i_cfg.wheel_ki);
                w_opb = MUL_B_W'(r_lint);
            end
            MS_LD: begin
                w_opa = MUL_A_W'(i_cfg.wheel_kd);
                w_opb = MUL_B_W'(r_del);
            end
            MS_RP: begin
                w_opa = MUL_A_W'(i_cfg.wheel_kp);
                w_opb = MUL_B_W'(r_errr);
            end
            MS_RI: begin
                w_opa = MUL_A_W'(i_cfg.wheel_ki);
                w_opb = MUL_B_W'(r_rint);
            end
            MS_RD: begin
                w_opa = MUL_A_W'(i_cfg.wheel_kd);
                w_opb = MUL_B_W'(r_der);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // truncation toward zero of the split products
    always_comb begin
        w_rnd_in  = r_prod + (r_prod[PROD_W-1] ? PROD_W'(SPLIT_ONE_IN - 1) : PROD_W'(0));
        w_rnd_out = r_prod + (r_prod[PROD_W-1] ? PROD_W'(SPLIT_ONE_OUT - 1) : PROD_W'(0));
        w_tin     = TGT_W'(w_rnd_in >>> SPLIT_IN_SH);
        w_tout    = TGT_W'(w_rnd_out >>> SPLIT_OUT_SH);
    end

    // steering: dead zone on the exact sum, truncate, saturate
    always_comb begin
        w_dead = (r_sacc <= DZ_HI) && (r_sacc >= DZ_LO);
        w_srnd = r_sacc + (r_sacc[SACC_W-1] ? SACC_W'(FRAC_ONE - 1) : SACC_W'(0));
        w_sq   = w_srnd >>> FRAC_W;
        if (w_sq > SACC_W'(STEER_MAX)) begin
            w_steer = STEER_W'(STEER_MAX);
        end else if (w_sq < SACC_W'(STEER_MIN)) begin
            w_steer = STEER_W'(STEER_MIN);
        end else begin
            w_steer = STEER_W'(w_sq);
        end
        w_mag = r_steer[STEER_W-1] ? (E_W'(0) - E_W'(r_steer)) : E_W'(r_steer);
    end

    // non-negative steer makes left the inner wheel
    always_comb begin
        w_tl   = r_steer[STEER_W-1] ? r_tout : r_tin;
        w_tr   = r_steer[STEER_W-1] ? r_tin  : r_tout;
        w_errl = f_sat_err(DIF_W'(w_tl) - DIF_W'(r_sl));
        w_errr = f_sat_err(DIF_W'(w_tr) - DIF_W'(r_sr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msel_q <= MS_NONE;
            r_prev_e <= '0;
            r_lprev  <= '0;
            r_rprev  <= '0;
            r_lint   <= '0;
            r_rint   <= '0;
        end else begin
            r_msel_q <= i_cmd.msel;
            if (i_cmd.load) begin
                r_prev_e <= w_e;
            end
            if (i_cmd.err) begin
                r_lprev <= w_errl;
                r_rprev <= w_errr;
            end
            if (i_cmd.integ) begin
                r_lint <= f_sat_int(ISUM_W'(r_lint) + ISUM_W'(r_errl));
                r_rint <= f_sat_int(ISUM_W'(r_rint) + ISUM_W'(r_errr));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_opa) * PROD_W'(w_opb);

        if (i_cmd.load) begin
            r_e    <= w_e;
            r_abse <= w_abse;
            r_de   <= DE_W'(w_e) - DE_W'(r_prev_e);
            r_gyro <= i_gyro_rate;
            r_sl   <= i_speed_left;
            r_sr   <= i_speed_right;
            r_sacc <= '0;
        end

        if (i_cmd.steer) begin
            r_steer <= w_dead ? STEER_W'(0) : w_steer;
        end
        if (i_cmd.kq) begin
            r_kq <= KQ_W'(w_mag) * KQ_W'(SPLIT_Q16);
        end
        if (i_cmd.err) begin
            r_errl <= w_errl;
            r_errr <= w_errr;
            r_del  <= WDERR_W'(w_errl) - WDERR_W'(r_lprev);
            r_der  <= WDERR_W'(w_errr) - WDERR_W'(r_rprev);
            r_lacc <= '0;
            r_racc <= '0;
        end

        unique case (r_msel_q)
            MS_EE:  r_ee   <= r_prod[EE_W-1:0];
            MS_KP:  r_sacc <= r_sacc + (r_prod <<< KD_SH);
            MS_KPP: r_sacc <= r_sacc + r_prod;
            MS_KD:  r_sacc <= r_sacc + (r_prod <<< KD_SH);
            MS_KDD: r_sacc <= r_sacc - (r_prod <<< KDD_SH);
            MS_IN:  r_tin  <= w_tin;
            MS_OUT: r_tout <= w_tout;
            MS_LP:  r_lacc <= r_lacc + WACC_W'(r_prod);
            MS_LI:  r_lacc <= r_lacc + WACC_W'(r_prod);
            MS_LD:  r_lacc <= r_lacc + WACC_W'(r_prod);
            MS_RP:  r_racc <= r_racc + WACC_W'(r_prod);
            MS_RI:  r_racc <= r_racc + WACC_W'(r_prod);
            MS_RD:  r_racc <= r_racc + WACC_W'(r_prod);
            default: ;
        endcase

        if (i_cmd.fin) begin
            r_drive_l   <= f_sat_pwm(r_lacc);
            r_drive_r   <= f_sat_pwm(r_racc);
            r_steer_out <= r_steer;
        end
    end

    a_lint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lint <= IW'(INTEGRAL_LIMIT)) && (r_lint >= IW'(-INTEGRAL_LIMIT)))
        else $error("left integral outside its limit");

    a_rint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rint <= IW'(INTEGRAL_LIMIT)) && (r_rint >= IW'(-INTEGRAL_LIMIT)))
        else $error("right integral outside its limit");

    // a sum just past the dead zone truncates to a magnitude of exactly DEAD_ZONE
    a_steer_dead_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.steer) |->
            (r_steer == '0 || r_steer >= STEER_W'(DEAD_ZONE)
             || r_steer <= STEER_W'(-DEAD_ZONE)))
        else $error("steer inside the dead zone but not zero");

endmodule

>>> rtl/differential_drive_steer_speed_pid_top.sv
// Top level of the steering PD and per-wheel speed PID controller.
//
//  channel  dir  modport  payload
//  i_in     in   sink     line_error, gyro_rate, speed_left, speed_right
//  o_out    out  source   drive_left, drive_right, steer_out
//  i_cfg    in   sink     idx (register 0..7), data
//
// A tick runs from input transfer to a loaded output register as one pass of the
// sequencer, which steps a single shared 18x32 multiplier over 13 products.
// The next tick is taken the cycle after the result is loaded; i_in is ready only
// between ticks. A stalled result holds in the output register while the next
// tick is already running. i_cfg is always ready.
// Reset is synchronous: registers return to their reset values, loop state clears.
module differential_drive_steer_speed_pid_top #(
    parameter int PWM_LIMIT      = dds_pkg::PWM_LIMIT_DEF,
    parameter int INTEGRAL_LIMIT = dds_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dds_in_if.sink    i_in,
    dds_out_if.source o_out,
    dds_cfg_if.sink   i_cfg
);
    import dds_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    dds_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    dds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    dds_dp #(
        .PWM_LIMIT      (PWM_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (w_cfg),
        .i_line_error  (i_in.line_error),
        .i_gyro_rate   (i_in.gyro_rate),
        .i_speed_left  (i_in.speed_left),
        .i_speed_right (i_in.speed_right),
        .o_drive_left  (o_out.drive_left),
        .o_drive_right (o_out.drive_right),
        .o_steer_out   (o_out.steer_out)
    );

endmodule
